### rtl/core/lfyp_pkg.sv
package lfyp_pkg;

  localparam int MAX_PAGES = 1024;
  localparam int ADDR_W    = $clog2(MAX_PAGES);
  localparam int CNT_W     = ADDR_W + 1;
  localparam int PC_W      = 11;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_PAGE_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHUFFLE_SEED = 2'd1;

  localparam logic [PC_W-1:0] PAGE_COUNT_RESET = PC_W'(1024);

  localparam int LCG_W    = 48;
  localparam int LCG_HALF = LCG_W / 2;
  localparam int RND_W    = 32;
  localparam int SEED_LO_W = LCG_W - RND_W;
  localparam logic [LCG_HALF-1:0]  LCG_MUL_LO   = 24'hECE66D;
  localparam logic [LCG_HALF-1:0]  LCG_MUL_HI   = 24'h0005DE;
  localparam logic [LCG_W-1:0]     LCG_ADD      = 48'hB;
  localparam logic [SEED_LO_W-1:0] LCG_LOW_SEED = 16'h330E;

  localparam int DVD_W     = 64;
  localparam int MOD_BITS  = 4;
  localparam int MOD_STEPS = DVD_W / MOD_BITS;
  localparam int MOD_CNT_W = $clog2(MOD_STEPS);

  typedef enum logic {
    REQ_SHUFFLE = 1'b0,
    REQ_READ    = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    ST_SHUFFLE_DONE = 2'd0,
    ST_READ_OK      = 2'd1,
    ST_OUT_OF_RANGE = 2'd2,
    ST_NOT_SHUFFLED = 2'd3
  } status_t;

  typedef struct packed {
    req_t              req_type;
    logic [ADDR_W-1:0] position;
  } in_data_t;

  typedef struct packed {
    logic [ADDR_W-1:0] page_index;
    logic [ADDR_W-1:0] next_page;
    logic [ADDR_W-1:0] prev_page;
    logic [ADDR_W-1:0] age;
    status_t           status;
  } out_data_t;

  typedef enum logic [1:0] {
    PH_LOLO   = 2'd0,
    PH_HILO   = 2'd1,
    PH_LOHI   = 2'd2,
    PH_FINISH = 2'd3
  } lcg_ph_t;

  typedef enum logic [2:0] {
    RS_POS  = 3'd0,
    RS_NEXT = 3'd1,
    RS_PREV = 3'd2,
    RS_IDX  = 3'd3,
    RS_J    = 3'd4
  } rsel_t;

  typedef enum logic [1:0] {
    WS_FILL    = 2'd0,
    WS_J_RDATA = 2'd1,
    WS_IDX_TMP = 2'd2
  } wsel_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'd0,
    S_CHECK = 4'd1,
    S_RD0   = 4'd2,
    S_RD1   = 4'd3,
    S_RD2   = 4'd4,
    S_RD3   = 4'd5,
    S_FILL  = 4'd6,
    S_RGO   = 4'd7,
    S_RWAIT = 4'd8,
    S_MWAIT = 4'd9,
    S_SW0   = 4'd10,
    S_SW1   = 4'd11,
    S_SW2   = 4'd12,
    S_SW3   = 4'd13,
    S_DONE  = 4'd14
  } state_t;

  typedef struct packed {
    logic    in_take;
    logic    idx_clr;
    logic    idx_inc;
    logic    idx_set1;
    logic    lcg_seed;
    logic    lcg_step;
    logic    mod_start;
    logic    j_load;
    logic    mem_we;
    wsel_t   wsel;
    rsel_t   rsel;
    logic    cap_tmp;
    logic    cap_page;
    logic    cap_next;
    logic    cap_prev;
    logic    set_ready;
    logic    out_load;
    status_t out_status;
  } cmd_t;

  typedef struct packed {
    logic table_ready;
    logic pos_oob;
    logic idx_last;
    logic lcg_done;
    logic mod_done;
    logic out_free;
  } sts_t;

endpackage

### rtl/core/lfyp_lcg.sv
module lfyp_lcg import lfyp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             seed_load,
  input  logic [RND_W-1:0] seed,
  input  logic             step,
  output logic             done,
  output logic [RND_W-1:0] rnd
);

  logic [LCG_W-1:0]    state_r;
  logic [LCG_W-1:0]    acc_r;
  logic [LCG_W-1:0]    prod_r;
  logic [LCG_W-1:0]    prod_nxt;
  logic [LCG_W-1:0]    prod_hi;
  logic [LCG_HALF-1:0] mul_a;
  logic [LCG_HALF-1:0] mul_b;
  lcg_ph_t             ph_r;
  logic                busy_r;
  logic                done_r;

  always_comb begin
    case (ph_r)
      PH_LOLO: begin
        mul_a = state_r[LCG_HALF-1:0];
        mul_b = LCG_MUL_LO;
      end
      PH_HILO: begin
        mul_a = state_r[LCG_W-1:LCG_HALF];
        mul_b = LCG_MUL_LO;
      end
      PH_LOHI: begin
        mul_a = state_r[LCG_HALF-1:0];
        mul_b = LCG_MUL_HI;
      end
      default: begin
        mul_a = state_r[LCG_HALF-1:0];
        mul_b = LCG_MUL_LO;
      end
    endcase
  end

  assign prod_nxt = LCG_W'(mul_a) * LCG_W'(mul_b);
  assign prod_hi  = {prod_r[LCG_HALF-1:0], {LCG_HALF{1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
      ph_r    <= PH_LOLO;
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (seed_load) begin
        state_r <= {seed, LCG_LOW_SEED};
        busy_r  <= 1'b0;
      end else if (step) begin
        busy_r <= 1'b1;
        ph_r   <= PH_LOLO;
      end else if (busy_r) begin
        case (ph_r)
          PH_LOLO:   ph_r <= PH_HILO;
          PH_HILO:   ph_r <= PH_LOHI;
          PH_LOHI:   ph_r <= PH_FINISH;
          PH_FINISH: begin
            state_r <= acc_r + prod_hi;
            busy_r  <= 1'b0;
            done_r  <= 1'b1;
          end
          default:   ph_r <= PH_LOLO;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      prod_r <= prod_nxt;
      case (ph_r)
        PH_LOLO: acc_r <= LCG_ADD;
        PH_HILO: acc_r <= acc_r + prod_r;
        PH_LOHI: acc_r <= acc_r + prod_hi;
        default: acc_r <= acc_r;
      endcase
    end
  end

  assign done = done_r;
  assign rnd  = state_r[LCG_W-1:SEED_LO_W];

endmodule

### rtl/core/lfyp_mod.sv
module lfyp_mod import lfyp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [RND_W-1:0]  dvd_in,
  input  logic [CNT_W-1:0]  dvs_in,
  output logic              done,
  output logic [ADDR_W-1:0] rem
);

  logic [DVD_W-1:0]     dvd_r;
  logic [CNT_W-1:0]     dvs_r;
  logic [ADDR_W-1:0]    rem_r;
  logic [ADDR_W-1:0]    rem_nxt;
  logic [MOD_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;

  always_comb begin
    logic [CNT_W-1:0]  t;
    logic [ADDR_W-1:0] r;
    r = rem_r;
    for (int k = 0; k < MOD_BITS; k++) begin
      t = {r, dvd_r[DVD_W-1-k]};
      if (t >= dvs_r) begin
        t = t - dvs_r;
      end
      r = t[ADDR_W-1:0];
    end
    rem_nxt = r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + MOD_CNT_W'(1);
        if (cnt_r == MOD_CNT_W'(MOD_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= {{(DVD_W - RND_W){dvd_in[RND_W-1]}}, dvd_in};
      dvs_r <= dvs_in;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_r << MOD_BITS;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

### rtl/core/lfyp_dp.sv
module lfyp_dp import lfyp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic [ADDR_W-1:0]     in_pos,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  out_ready,
  output logic                  out_valid,
  output out_data_t             out_data
);

  logic [PC_W-1:0]   page_count_r;
  logic [RND_W-1:0]  seed_r;
  logic              table_ready_r;
  logic [CNT_W-1:0]  cnt_n;
  logic [CNT_W-1:0]  n_m1;
  logic [CNT_W-1:0]  pos_inc;
  logic [ADDR_W-1:0] next_pos;
  logic [ADDR_W-1:0] prev_pos;
  logic [ADDR_W-1:0] pos_r;
  logic [ADDR_W-1:0] idx_r;
  logic [ADDR_W-1:0] j_r;
  logic [ADDR_W-1:0] tmp_r;
  logic [ADDR_W-1:0] pg_r;
  logic [ADDR_W-1:0] nx_r;
  logic [ADDR_W-1:0] pv_r;
  logic [ADDR_W-1:0] rdata_r;
  logic [ADDR_W-1:0] raddr;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] wdata;
  logic [ADDR_W-1:0] mem [MAX_PAGES];
  logic [RND_W-1:0]  rnd;
  logic [ADDR_W-1:0] mod_rem;
  logic              lcg_done;
  logic              mod_done;
  logic              out_valid_r;
  out_data_t         out_data_r;

  always_comb begin
    if (page_count_r < PC_W'(2)) begin
      cnt_n = CNT_W'(2);
    end else if (32'(page_count_r) > 32'(MAX_PAGES)) begin
      cnt_n = CNT_W'(MAX_PAGES);
    end else begin
      cnt_n = CNT_W'(page_count_r);
    end
  end

  assign n_m1     = cnt_n - CNT_W'(1);
  assign pos_inc  = CNT_W'(pos_r) + CNT_W'(1);
  assign next_pos = (pos_inc == cnt_n) ? '0 : pos_inc[ADDR_W-1:0];
  assign prev_pos = (pos_r == '0) ? n_m1[ADDR_W-1:0] : pos_r - ADDR_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_count_r  <= PAGE_COUNT_RESET;
      seed_r        <= '0;
      table_ready_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == REG_PAGE_COUNT) begin
        page_count_r  <= cfg_wdata[PC_W-1:0];
        table_ready_r <= 1'b0;
      end else if (cmd.set_ready) begin
        table_ready_r <= 1'b1;
      end
      if (cfg_we && cfg_index == REG_SHUFFLE_SEED) begin
        seed_r <= cfg_wdata[RND_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_take) pos_r <= in_pos;
    if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_set1) begin
      idx_r <= ADDR_W'(1);
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + ADDR_W'(1);
    end
    if (cmd.j_load)   j_r   <= mod_rem;
    if (cmd.cap_tmp)  tmp_r <= rdata_r;
    if (cmd.cap_page) pg_r  <= rdata_r;
    if (cmd.cap_next) nx_r  <= rdata_r;
    if (cmd.cap_prev) pv_r  <= rdata_r;
  end

  always_comb begin
    case (cmd.rsel)
      RS_POS:  raddr = pos_r;
      RS_NEXT: raddr = next_pos;
      RS_PREV: raddr = prev_pos;
      RS_IDX:  raddr = idx_r;
      RS_J:    raddr = j_r;
      default: raddr = pos_r;
    endcase
    case (cmd.wsel)
      WS_FILL: begin
        waddr = idx_r;
        wdata = idx_r;
      end
      WS_J_RDATA: begin
        waddr = j_r;
        wdata = rdata_r;
      end
      WS_IDX_TMP: begin
        waddr = idx_r;
        wdata = tmp_r;
      end
      default: begin
        waddr = idx_r;
        wdata = idx_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  lfyp_lcg u_lcg (
    .clk       (clk),
    .rst_n     (rst_n),
    .seed_load (cmd.lcg_seed),
    .seed      (seed_r),
    .step      (cmd.lcg_step),
    .done      (lcg_done),
    .rnd       (rnd)
  );

  lfyp_mod u_mod (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.mod_start),
    .dvd_in (rnd),
    .dvs_in (CNT_W'(idx_r) + CNT_W'(1)),
    .done   (mod_done),
    .rem    (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.status <= cmd.out_status;
      if (cmd.out_status == ST_READ_OK) begin
        out_data_r.page_index <= pg_r;
        out_data_r.next_page  <= nx_r;
        out_data_r.prev_page  <= pv_r;
        out_data_r.age        <= pos_r;
      end else begin
        out_data_r.page_index <= '0;
        out_data_r.next_page  <= '0;
        out_data_r.prev_page  <= '0;
        out_data_r.age        <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sts.table_ready = table_ready_r;
  assign sts.pos_oob     = CNT_W'(pos_r) >= cnt_n;
  assign sts.idx_last    = CNT_W'(idx_r) == n_m1;
  assign sts.lcg_done    = lcg_done;
  assign sts.mod_done    = mod_done;
  assign sts.out_free    = !out_valid_r || out_ready;

endmodule

### rtl/core/lfyp_ctrl.sv
module lfyp_ctrl import lfyp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  req_t in_req,
  output logic in_ready,
  output cmd_t cmd,
  input  sts_t sts
);

  state_t  state_r;
  state_t  state_nxt;
  status_t st_r;
  status_t st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= ST_SHUFFLE_DONE;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_req == REQ_SHUFFLE) ? S_FILL : S_CHECK;
        end
      end
      S_CHECK: begin
        if (!sts.table_ready) begin
          st_nxt    = ST_NOT_SHUFFLED;
          state_nxt = S_DONE;
        end else if (sts.pos_oob) begin
          st_nxt    = ST_OUT_OF_RANGE;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_RD0;
        end
      end
      S_RD0: state_nxt = S_RD1;
      S_RD1: state_nxt = S_RD2;
      S_RD2: state_nxt = S_RD3;
      S_RD3: begin
        st_nxt    = ST_READ_OK;
        state_nxt = S_DONE;
      end
      S_FILL: begin
        if (sts.idx_last) state_nxt = S_RGO;
      end
      S_RGO: state_nxt = S_RWAIT;
      S_RWAIT: begin
        if (sts.lcg_done) state_nxt = S_MWAIT;
      end
      S_MWAIT: begin
        if (sts.mod_done) state_nxt = S_SW0;
      end
      S_SW0: state_nxt = S_SW1;
      S_SW1: state_nxt = S_SW2;
      S_SW2: state_nxt = S_SW3;
      S_SW3: begin
        if (sts.idx_last) begin
          st_nxt    = ST_SHUFFLE_DONE;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_RGO;
        end
      end
      S_DONE: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.rsel       = RS_POS;
    cmd.wsel       = WS_FILL;
    cmd.out_status = st_r;
    in_ready       = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.in_take = in_valid;
        cmd.idx_clr = in_valid;
      end
      S_RD0: cmd.rsel = RS_POS;
      S_RD1: begin
        cmd.rsel     = RS_NEXT;
        cmd.cap_page = 1'b1;
      end
      S_RD2: begin
        cmd.rsel     = RS_PREV;
        cmd.cap_next = 1'b1;
      end
      S_RD3: cmd.cap_prev = 1'b1;
      S_FILL: begin
        cmd.mem_we = 1'b1;
        cmd.wsel   = WS_FILL;
        if (sts.idx_last) begin
          cmd.idx_set1 = 1'b1;
          cmd.lcg_seed = 1'b1;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_RGO: cmd.lcg_step = 1'b1;
      S_RWAIT: cmd.mod_start = sts.lcg_done;
      S_MWAIT: cmd.j_load = sts.mod_done;
      S_SW0: cmd.rsel = RS_J;
      S_SW1: begin
        cmd.rsel    = RS_IDX;
        cmd.cap_tmp = 1'b1;
      end
      S_SW2: begin
        cmd.mem_we = 1'b1;
        cmd.wsel   = WS_J_RDATA;
      end
      S_SW3: begin
        cmd.mem_we = 1'b1;
        cmd.wsel   = WS_IDX_TMP;
        if (sts.idx_last) begin
          cmd.set_ready = 1'b1;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_DONE: cmd.out_load = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

### rtl/core/lcg_fisher_yates_permuter.sv
// Random page permuter with ring lookups.
// Input transfer (in_valid/in_ready, in_data): req_type REQ_SHUFFLE rebuilds the
// table as a random permutation of 0..count-1; REQ_READ returns the entry at
// position with its ring neighbours and its age. Every transfer yields exactly one
// result on out_valid/out_ready/out_data, in order.
// cfg_we/cfg_index/cfg_wdata write page_count and shuffle_seed; write them only
// while the block is idle. Writing page_count invalidates the table.
// A read steps from S_CHECK through S_RD0..S_RD3 to S_DONE; a failed read goes
// from S_CHECK straight to S_DONE. A shuffle is an identity fill of one entry a
// cycle, then per position a 4-phase generator update on one shared 24x24
// multiplier, a remainder unit at 4 bits a cycle, and a swap in S_SW0..S_SW3 on
// the table memory, which has one read port and one write port.
// One item is in flight at a time; in_ready is high only while idle.
// The result sits in an output register; a stalled receiver holds it and the
// block waits with its next result until that register is free.
// Reset is synchronous (rst_n low): the table is marked not shuffled, so reads
// answer ST_NOT_SHUFFLED until a shuffle completes. No clearing pass is needed.
module lcg_fisher_yates_permuter import lfyp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_data_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_data_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  lfyp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_req   (in_data.req_type),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  lfyp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_pos    (in_data.position),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

### rtl/core/lfyp_checker.sv
module lfyp_checker import lfyp_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input out_data_t             out_data,
  input logic                  cfg_we
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transfer taken while busy");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_READ_OK |->
      out_data.page_index == '0 && out_data.next_page == '0 &&
      out_data.prev_page == '0 && out_data.age == '0)
    else $error("non-read result carries data");

  a_ring_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_READ_OK |->
      out_data.page_index != out_data.next_page &&
      out_data.page_index != out_data.prev_page)
    else $error("neighbour repeats the entry");

  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |-> in_ready && !out_valid)
    else $error("register written while a transfer is in flight");

endmodule

bind lcg_fisher_yates_permuter lfyp_checker u_lfyp_checker (.*);
